// ----- rtl/core/lmsanc_pkg.sv -----
`timescale 1ns / 1ps

package lmsanc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned WeightW = 24;
  localparam int unsigned StepW   = 16;
  localparam int unsigned FiltProdW = WeightW + SampleW;
  localparam int unsigned MuErrW  = StepW + 1 + SampleW;
  localparam int unsigned UpdProdW = MuErrW + SampleW;
  localparam int unsigned UpdShift = 24;
  localparam int unsigned AccShift = 22;
  localparam logic [StepW-1:0] StepReset = 16'd328;

  typedef struct packed {
    logic shift_x;
    logic rotate;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/lmsanc_cell.sv -----
`timescale 1ns / 1ps

module lmsanc_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lmsanc_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [lmsanc_pkg::SampleW-1:0] x_i,
  input  logic signed [lmsanc_pkg::WeightW-1:0] w_i,
  output logic signed [lmsanc_pkg::SampleW-1:0] x_o,
  output logic signed [lmsanc_pkg::WeightW-1:0] w_o
);

  logic signed [lmsanc_pkg::SampleW-1:0] x_q, x_d;
  logic signed [lmsanc_pkg::WeightW-1:0] w_q, w_d;

  always_comb begin
    x_d = x_q;
    w_d = w_q;
    if (ctrl_i.shift_x) begin
      x_d = x_i;
    end else if (ctrl_i.rotate) begin
      x_d = x_i;
      w_d = w_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      w_q <= '0;
    end else begin
      x_q <= x_d;
      w_q <= w_d;
    end
  end

  assign x_o = x_q;
  assign w_o = w_q;

endmodule

// ----- rtl/core/lms_adaptive_noise_canceller.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Beat fields (lowest bits first)
// s_axis   | in        | reference_sample[15:0], primary_sample[31:16]
// m_axis   | out       | error_sample[15:0], filter_output[31:16]
// cfg      | in        | step_size[15:0], written when cfg_we_i is high
//
// An item takes these steps in order: the delay line shifts, the estimate accumulates
// tap by tap on the shared multiplier, the error is formed, then step times error is
// formed, and the weights are updated tap by tap as they circulate.
// Reset clears the delay line and weights and loads the step size with 328.
// A result waiting on the output stalls the block at the error cycle only.

module lms_adaptive_noise_canceller #(
  parameter int unsigned TAPS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // reference_sample, primary_sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // error_sample, filter_output
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned SW = lmsanc_pkg::SampleW;
  localparam int unsigned WW = lmsanc_pkg::WeightW;
  localparam int unsigned AccW = lmsanc_pkg::FiltProdW + $clog2(TAPS);
  localparam int unsigned CntW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned UpdW = lmsanc_pkg::UpdProdW - lmsanc_pkg::UpdShift;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFilt = 3'd1;
  localparam logic [2:0] StErr  = 3'd2;
  localparam logic [2:0] StMue  = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [lmsanc_pkg::StepW-1:0] step_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [SW-1:0] prim_q;
  logic signed [SW-1:0] err_q, err_d;
  logic signed [SW-1:0] y_d;
  logic signed [lmsanc_pkg::MuErrW-1:0] mue_q;
  logic [31:0] out_data_q;
  logic out_valid_q, out_valid_d;
  logic load_out;

  logic signed [SW-1:0] x_arr [TAPS];
  logic signed [WW-1:0] w_arr [TAPS];
  logic signed [SW-1:0] x_in [TAPS];
  logic signed [WW-1:0] w_in [TAPS];
  lmsanc_pkg::cell_ctrl_t ctrl;

  logic signed [SW-1:0] x_last;
  logic signed [WW-1:0] w_last;
  logic signed [lmsanc_pkg::FiltProdW-1:0] prod_f;
  logic signed [lmsanc_pkg::UpdProdW-1:0] prod_u;
  logic signed [WW+1:0] w_sum;
  logic signed [WW-1:0] w_new;
  logic signed [SW:0] e_wide;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);

  assign x_last = x_arr[TAPS-1];
  assign w_last = w_arr[TAPS-1];
  assign prod_f = w_last * x_last;
  assign prod_u = mue_q * x_last;
  assign w_sum = (WW+2)'(w_last) + (WW+2)'($signed(prod_u[lmsanc_pkg::UpdProdW-1 -: UpdW]));

  always_comb begin
    if (w_sum[WW+1:WW-1] == 3'b000 || w_sum[WW+1:WW-1] == 3'b111) begin
      w_new = w_sum[WW-1:0];
    end else if (w_sum[WW+1]) begin
      w_new = {1'b1, {(WW-1){1'b0}}};
    end else begin
      w_new = {1'b0, {(WW-1){1'b1}}};
    end
  end

  assign ctrl.shift_x = s_acc;
  assign ctrl.rotate  = (state_q == StFilt) || (state_q == StUpd);

  always_comb begin
    x_in[0] = s_acc ? $signed(s_axis_tdata_i[SW-1:0]) : x_last;
    w_in[0] = (state_q == StUpd) ? w_new : w_last;
    for (int k = 1; k < TAPS; k++) begin
      x_in[k] = x_arr[k-1];
      w_in[k] = w_arr[k-1];
    end
  end

  for (genvar g = 0; g < TAPS; g++) begin : g_cell
    lmsanc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .x_i    (x_in[g]),
      .w_i    (w_in[g]),
      .x_o    (x_arr[g]),
      .w_o    (w_arr[g])
    );
  end

  always_comb begin
    logic [AccW-lmsanc_pkg::AccShift-SW:0] hi;
    hi = acc_q[AccW-1:lmsanc_pkg::AccShift+SW-1];
    if ((&hi) || !(|hi)) begin
      y_d = acc_q[lmsanc_pkg::AccShift +: SW];
    end else if (acc_q[AccW-1]) begin
      y_d = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(SW-1){1'b1}}};
    end
    e_wide = (SW+1)'(prim_q) - (SW+1)'(y_d);
    if (e_wide[SW] == e_wide[SW-1]) begin
      err_d = e_wide[SW-1:0];
    end else if (e_wide[SW]) begin
      err_d = {1'b1, {(SW-1){1'b0}}};
    end else begin
      err_d = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    load_out = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          state_d = StFilt;
          cnt_d = '0;
          acc_d = '0;
        end
      end
      StFilt: begin
        acc_d = acc_q + AccW'(prod_f);
        if (cnt_q == CntW'(TAPS-1)) begin
          state_d = StErr;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      StErr: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StMue;
        end
      end
      StMue: begin
        state_d = StUpd;
      end
      StUpd: begin
        if (cnt_q == CntW'(TAPS-1)) begin
          state_d = StIdle;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      step_q <= lmsanc_pkg::StepReset;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (s_acc) begin
      prim_q <= $signed(s_axis_tdata_i[2*SW-1:SW]);
    end
    if (load_out) begin
      err_q <= err_d;
      out_data_q <= {y_d, err_d};
    end
    if (state_q == StMue) begin
      mue_q <= $signed({1'b0, step_q}) * err_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;

endmodule

// ----- dv/tb_lms_adaptive_noise_canceller.sv -----
`timescale 1ns / 1ps

module tb_lms_adaptive_noise_canceller;

  localparam int unsigned Taps = 5;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned PhaseItems = 320;
  localparam int unsigned RxHoldCycles = 400;
  localparam longint SampleMax = 64'sd32767;
  localparam longint SampleMin = -64'sd32768;
  localparam longint WeightMax = 64'sd8388607;
  localparam longint WeightMin = -64'sd8388608;

  typedef struct packed {
    logic signed [lmsanc_pkg::SampleW-1:0] filter_output;
    logic signed [lmsanc_pkg::SampleW-1:0] error_sample;
  } result_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  logic signed [lmsanc_pkg::WeightW-1:0] weight_q [Taps];
  logic signed [lmsanc_pkg::SampleW-1:0] history_q [Taps-1];
  logic [lmsanc_pkg::StepW-1:0]          step_q;

  result_beat_t expected_q [$];
  result_beat_t seen_beat;
  result_beat_t want_beat;
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  rx_hold_reqs = 0;
  int unsigned  rx_hold_done = 0;
  bit           tx_idle_en;
  bit           rx_idle_en;

  lms_adaptive_noise_canceller #(
    .TAPS(Taps)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void lms_clear();
    int k;
    for (k = 0; k < Taps; k++) weight_q[k] = '0;
    for (k = 0; k < Taps - 1; k++) history_q[k] = '0;
    step_q = lmsanc_pkg::StepReset;
  endfunction

  function automatic result_beat_t lms_predict(
    input logic signed [lmsanc_pkg::SampleW-1:0] x_new,
    input logic signed [lmsanc_pkg::SampleW-1:0] s_new
  );
    longint       taps [Taps];
    longint       acc;
    longint       est;
    longint       err;
    longint       upd;
    int           k;
    result_beat_t res;
    taps[0] = longint'(x_new);
    for (k = 1; k < Taps; k++) taps[k] = longint'(history_q[k-1]);
    acc = 0;
    for (k = 0; k < Taps; k++) acc += longint'(weight_q[k]) * taps[k];
    est = sat(acc >>> lmsanc_pkg::AccShift, SampleMin, SampleMax);
    err = sat(longint'(s_new) - est, SampleMin, SampleMax);
    for (k = 0; k < Taps; k++) begin
      upd = longint'(step_q) * err * taps[k];
      upd = sat(longint'(weight_q[k]) + (upd >>> lmsanc_pkg::UpdShift), WeightMin, WeightMax);
      weight_q[k] = upd[lmsanc_pkg::WeightW-1:0];
    end
    for (k = Taps - 2; k > 0; k--) history_q[k] = history_q[k-1];
    history_q[0] = x_new;
    res.error_sample  = err[lmsanc_pkg::SampleW-1:0];
    res.filter_output = est[lmsanc_pkg::SampleW-1:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic send_sample(input logic [15:0] x, input logic [15:0] s);
    int unsigned gap;
    gap = pick_gap(tx_idle_en);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {s, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(lms_predict(x, s));
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic write_step(input logic [15:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    step_q = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_samples(input int unsigned count);
    int unsigned n;
    int unsigned kind;
    longint      xi;
    longint      si;
    logic [15:0] x;
    logic [15:0] s;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      x = 16'($urandom());
      s = 16'($urandom());
      if (kind < 6) begin
        // The primary carries a scaled copy of the reference, so the weights converge.
        xi = longint'($signed(x));
        si = (xi >>> $urandom_range(0, 3)) + longint'($urandom_range(0, 512)) - 256;
        si = sat(si, SampleMin, SampleMax);
        s = si[15:0];
      end else if (kind < 8) begin
        xi = longint'($urandom_range(0, 128)) - 64;
        si = longint'($urandom_range(0, 128)) - 64;
        x = xi[15:0];
        s = si[15:0];
      end
      send_sample(x, s);
    end
  endtask

  task automatic test_directed_extremes();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h0001, 16'hffff);
    send_sample(16'hffff, 16'h0001);
    write_step(16'hffff);
    repeat (4) send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    write_step(16'h0000);
    send_sample(16'h3039, 16'hcfc7);
    send_sample(16'hffff, 16'h0000);
    send_sample(16'h0000, 16'h0000);
  endtask

  task automatic test_step_sweep();
    write_step(lmsanc_pkg::StepReset);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_samples(PhaseItems);
    write_step(16'($urandom_range(1, 2000)));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_random_samples(PhaseItems);
    write_step(16'hffff);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    send_random_samples(PhaseItems);
    write_step(16'h0000);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    send_random_samples(PhaseItems);
    write_step(16'h0001);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_random_samples(PhaseItems);
    write_step(16'($urandom()));
    send_random_samples(PhaseItems);
  endtask

  task automatic test_output_backpressure();
    write_step(lmsanc_pkg::StepReset);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_reqs++;
    send_random_samples(40);
    rx_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    tx_idle_en = 1'b1;
    send_random_samples(20);
    wait_drained();
    send_random_samples(20);
  endtask

  // One result beat is compared with the oldest prediction at each accepted output beat.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_beat = result_beat_t'(m_axis_tdata_o);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result beat with nothing expected: error_sample %0d, filter_output %0d",
                   seen_beat.error_sample, seen_beat.filter_output);
      end else begin
        want_beat = expected_q.pop_front();
        if (seen_beat.error_sample !== want_beat.error_sample)
          report_mismatch("error_sample", want_beat.error_sample, seen_beat.error_sample);
        if (seen_beat.filter_output !== want_beat.filter_output)
          report_mismatch("filter_output", want_beat.filter_output, seen_beat.filter_output);
      end
    end
  end

  initial begin
    int unsigned gap;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_reqs != rx_hold_done) begin
        m_axis_tready_i <= 1'b0;
        repeat (RxHoldCycles - 1) @(posedge clk_i);
        rx_hold_done++;
      end else begin
        gap = pick_gap(rx_idle_en);
        if (gap != 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    lms_clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_step_sweep();
    test_output_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
